@@ hw/rtl/hvn_pkg.sv @@
package hvn_pkg;

    // Fixed-point format of the coordinates.
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int CELL_W    = 32;
    localparam int HASH_W    = 32;
    localparam int SEED_W    = 32;

    // Corner values and the noise result share one signed width.
    localparam int NOISE_W   = 25;
    localparam int DIFF_W    = NOISE_W + 1;
    localparam int PROD_W    = DIFF_W + FRAC_BITS + 1;

    // Ease curve widths.
    localparam int EASE_Q_W  = FRAC_BITS + 2;
    localparam int TSQ_W     = 2 * FRAC_BITS;
    localparam int EPROD_W   = TSQ_W + EASE_Q_W;

    localparam int NUM_CORNERS = 8;

    // Pipeline register stages, in order.
    localparam int STG_IN     = 0;
    localparam int STG_MIX1   = 1;
    localparam int STG_MIX2   = 2;
    localparam int STG_CORNER = 3;
    localparam int STG_XMUL   = 4;
    localparam int STG_XADD   = 5;
    localparam int STG_YMUL   = 6;
    localparam int STG_YADD   = 7;
    localparam int STG_ZMUL   = 8;
    localparam int STG_ZADD   = 9;
    localparam int NUM_STAGES = 10;

    // Spatial hash primes and mixer constants.
    localparam logic [HASH_W-1:0] HASH_X    = 32'd73856093;
    localparam logic [HASH_W-1:0] HASH_Y    = 32'd19349663;
    localparam logic [HASH_W-1:0] HASH_Z    = 32'd83492791;
    localparam logic [HASH_W-1:0] MIX_XOR   = 32'h6a09e667;
    localparam logic [HASH_W-1:0] MIX_MUL1  = 32'h85ebca6b;
    localparam logic [HASH_W-1:0] MIX_MUL2  = 32'hc2b2ae35;
    localparam int               MIX_SHIFT1 = 13;
    localparam int               MIX_SHIFT2 = 16;
    localparam int               CORNER_BITS = 24;
    localparam logic [NOISE_W-1:0] CORNER_OFS = 25'h0FFFFFF;

    typedef logic signed [NOISE_W-1:0] noise_t;
    typedef logic [FRAC_BITS-1:0]      ease_t;

    // Per-stage load enables and valid bits of the pipeline.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctl_t;

endpackage

@@ hw/rtl/hashed_value_noise_3d.sv @@
// Channel  | Signals                          | Role
// ---------+----------------------------------+-----------------------------------
// cfg      | cfg_valid, cfg_ready, cfg_data   | seed write, always ready
// in       | in_valid, in_ready, coord_x/y/z  | one point per transaction, Q16.16
// out      | out_valid, out_ready, noise_value| one noise value per transaction
//
// Ten register stages: base hash products, two mixer multiplies, corner values,
// then a multiply and an add stage for each of the x, y and z blends.
// A point can enter every cycle unless a stalled output has filled every stage;
// its result is shown from the z add stage, which is the output register.
// Each stage loads whenever it is empty or its successor moves, so bubbles
// close up behind a stalled output and no transaction is lost or repeated.
// Reset clears the valid bits and the seed; payload registers are not reset.
module hashed_value_noise_3d
    import hvn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [SEED_W-1:0]         cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [NOISE_W-1:0] noise_value
);

    pipe_ctl_t         ctl;
    logic [SEED_W-1:0] seed_reg;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
    noise_t            corner_val [NUM_CORNERS];
    ease_t             ease_x;
    ease_t             ease_y;
    ease_t             ease_z;
    noise_t            edge_val  [4];
    noise_t            plane_val [2];
    noise_t            final_val;

    // Seed register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_valid)
        begin
            seed_reg <= cfg_data;
        end
    end

    // Pipeline flow control.
    hvn_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    // Lattice cell by floor shift.
    assign cell_x = CELL_W'(coord_x >>> FRAC_BITS);
    assign cell_y = CELL_W'(coord_y >>> FRAC_BITS);
    assign cell_z = CELL_W'(coord_z >>> FRAC_BITS);

    hvn_hash u_hash (
        .clk        (clk),
        .ctl        (ctl),
        .seed       (seed_reg),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_z     (cell_z),
        .corner_val (corner_val)
    );

    hvn_ease u_ease (
        .clk    (clk),
        .ctl    (ctl),
        .frac_x (coord_x[FRAC_BITS-1:0]),
        .frac_y (coord_y[FRAC_BITS-1:0]),
        .frac_z (coord_z[FRAC_BITS-1:0]),
        .ease_x (ease_x),
        .ease_y (ease_y),
        .ease_z (ease_z)
    );

    // Blend along x: edge index = 2y + z.
    for (genvar e = 0; e < 4; e++)
    begin : g_xlerp
        hvn_lerp u_lerp (
            .clk      (clk),
            .load_mul (ctl.load[STG_XMUL]),
            .load_add (ctl.load[STG_XADD]),
            .val_a    (corner_val[e]),
            .val_b    (corner_val[e+4]),
            .weight   (ease_x),
            .result   (edge_val[e])
        );
    end

    // Blend along y: one plane per z.
    for (genvar k = 0; k < 2; k++)
    begin : g_ylerp
        hvn_lerp u_lerp (
            .clk      (clk),
            .load_mul (ctl.load[STG_YMUL]),
            .load_add (ctl.load[STG_YADD]),
            .val_a    (edge_val[k]),
            .val_b    (edge_val[k+2]),
            .weight   (ease_y),
            .result   (plane_val[k])
        );
    end

    // Blend along z; its add stage is the output register.
    hvn_lerp u_zlerp (
        .clk      (clk),
        .load_mul (ctl.load[STG_ZMUL]),
        .load_add (ctl.load[STG_ZADD]),
        .val_a    (plane_val[0]),
        .val_b    (plane_val[1]),
        .weight   (ease_z),
        .result   (final_val)
    );

    assign noise_value = final_val;

endmodule

@@ hw/rtl/hvn_pipe_ctrl.sv @@
module hvn_pipe_ctrl
    import hvn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output pipe_ctl_t ctl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    // A stage loads when it is empty or when the stage after it loads.
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    // Valid bits move along with the data.
    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign ctl.load  = load;
    assign ctl.valid = valid_reg;

endmodule

@@ hw/rtl/hvn_ease.sv @@
module hvn_ease
    import hvn_pkg::*;
(
    input  logic                 clk,
    input  pipe_ctl_t            ctl,
    input  logic [FRAC_BITS-1:0] frac_x,
    input  logic [FRAC_BITS-1:0] frac_y,
    input  logic [FRAC_BITS-1:0] frac_z,
    output ease_t                ease_x,
    output ease_t                ease_y,
    output ease_t                ease_z
);

    localparam logic [EASE_Q_W-1:0] EASE_THREE = EASE_Q_W'(3) << FRAC_BITS;

    logic [FRAC_BITS-1:0] t_reg   [3];
    logic [TSQ_W-1:0]     tsq_reg [3];
    logic [EASE_Q_W-1:0]  q       [3];
    logic [EPROD_W-1:0]   eprod   [3];
    ease_t                s1_reg  [3];
    ease_t                s2_reg  [3];
    ease_t                sx3_reg;
    ease_t                syz3_reg [2];
    ease_t                syz4_reg [2];
    ease_t                sy5_reg;
    ease_t                sz5_reg;
    ease_t                sz6_reg;
    ease_t                sz7_reg;

    // First stage: square the fraction.
    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_IN])
        begin
            t_reg[0]   <= frac_x;
            t_reg[1]   <= frac_y;
            t_reg[2]   <= frac_z;
            tsq_reg[0] <= TSQ_W'(frac_x) * TSQ_W'(frac_x);
            tsq_reg[1] <= TSQ_W'(frac_y) * TSQ_W'(frac_y);
            tsq_reg[2] <= TSQ_W'(frac_z) * TSQ_W'(frac_z);
        end
    end

    // Second stage: t*t*(3 - 2t), keeping the integer-scaled top bits.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            q[a]     = EASE_THREE - (EASE_Q_W'(t_reg[a]) << 1);
            eprod[a] = EPROD_W'(tsq_reg[a]) * EPROD_W'(q[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_MIX1])
        begin
            for (int a = 0; a < 3; a++)
            begin
                s1_reg[a] <= eprod[a][3*FRAC_BITS-1:2*FRAC_BITS];
            end
        end
    end

    // Delay each weight until its interpolation level uses it.
    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_MIX2])
        begin
            s2_reg <= s1_reg;
        end
        if (ctl.load[STG_CORNER])
        begin
            sx3_reg     <= s2_reg[0];
            syz3_reg[0] <= s2_reg[1];
            syz3_reg[1] <= s2_reg[2];
        end
        if (ctl.load[STG_XMUL])
        begin
            syz4_reg <= syz3_reg;
        end
        if (ctl.load[STG_XADD])
        begin
            sy5_reg <= syz4_reg[0];
            sz5_reg <= syz4_reg[1];
        end
        if (ctl.load[STG_YMUL])
        begin
            sz6_reg <= sz5_reg;
        end
        if (ctl.load[STG_YADD])
        begin
            sz7_reg <= sz6_reg;
        end
    end

    assign ease_x = sx3_reg;
    assign ease_y = sy5_reg;
    assign ease_z = sz7_reg;

endmodule

@@ hw/rtl/hvn_hash.sv @@
module hvn_hash
    import hvn_pkg::*;
(
    input  logic              clk,
    input  pipe_ctl_t         ctl,
    input  logic [SEED_W-1:0] seed,
    input  logic [CELL_W-1:0] cell_x,
    input  logic [CELL_W-1:0] cell_y,
    input  logic [CELL_W-1:0] cell_z,
    output noise_t            corner_val [NUM_CORNERS]
);

    logic [HASH_W-1:0] hx_reg;
    logic [HASH_W-1:0] hy_reg;
    logic [HASH_W-1:0] hz_reg;
    logic [HASH_W-1:0] hxs [2];
    logic [HASH_W-1:0] hys [2];
    logic [HASH_W-1:0] hzs [2];
    logic [HASH_W-1:0] pre  [NUM_CORNERS];
    logic [HASH_W-1:0] m1_reg [NUM_CORNERS];
    logic [HASH_W-1:0] m1x  [NUM_CORNERS];
    logic [HASH_W-1:0] m2_reg [NUM_CORNERS];
    logic [HASH_W-1:0] hfin [NUM_CORNERS];
    noise_t            corner_reg [NUM_CORNERS];

    // Base products of the cell; the +1 corner adds the prime once more.
    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_IN])
        begin
            hx_reg <= cell_x * HASH_X;
            hy_reg <= cell_y * HASH_Y;
            hz_reg <= cell_z * HASH_Z;
        end
    end

    // Combine per corner (index = 4x + 2y + z) and run the first mix multiply.
    always_comb
    begin
        hxs[0] = hx_reg;
        hxs[1] = hx_reg + HASH_X;
        hys[0] = hy_reg;
        hys[1] = hy_reg + HASH_Y;
        hzs[0] = hz_reg;
        hzs[1] = hz_reg + HASH_Z;
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            pre[c] = hxs[c/4] ^ hys[(c/2)%2] ^ hzs[c%2] ^ seed ^ MIX_XOR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_MIX1])
        begin
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                m1_reg[c] <= pre[c] * MIX_MUL1;
            end
        end
    end

    // Second mix round.
    always_comb
    begin
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            m1x[c] = m1_reg[c] ^ (m1_reg[c] >> MIX_SHIFT1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_MIX2])
        begin
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                m2_reg[c] <= m1x[c] * MIX_MUL2;
            end
        end
    end

    // Final fold and mapping of the low bits to a signed corner value.
    always_comb
    begin
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            hfin[c] = m2_reg[c] ^ (m2_reg[c] >> MIX_SHIFT2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_CORNER])
        begin
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                corner_reg[c] <= {hfin[c][CORNER_BITS-1:0], 1'b0} - CORNER_OFS;
            end
        end
    end

    assign corner_val = corner_reg;

endmodule

@@ hw/rtl/hvn_lerp.sv @@
module hvn_lerp
    import hvn_pkg::*;
(
    input  logic   clk,
    input  logic   load_mul,
    input  logic   load_add,
    input  noise_t val_a,
    input  noise_t val_b,
    input  ease_t  weight,
    output noise_t result
);

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    noise_t                   a_reg;
    logic signed [PROD_W-1:0] shifted;
    logic signed [DIFF_W-1:0] sum;
    noise_t                   result_reg;

    // Multiply stage: (b - a) * s.
    always_comb
    begin
        diff = DIFF_W'(val_b) - DIFF_W'(val_a);
        prod = PROD_W'(diff) * PROD_W'($signed({1'b0, weight}));
    end

    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            prod_reg <= prod;
            a_reg    <= val_a;
        end
    end

    // Add stage: a + floor(product / 2^FRAC_BITS); the sum stays between a and b.
    always_comb
    begin
        shifted = prod_reg >>> FRAC_BITS;
        sum     = DIFF_W'(a_reg) + $signed(shifted[DIFF_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (load_add)
        begin
            result_reg <= sum[NOISE_W-1:0];
        end
    end

    assign result = result_reg;

endmodule

@@ hw/rtl/hvn_checker.sv @@
module hvn_checker
    import hvn_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [SEED_W-1:0]         cfg_data,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic signed [COORD_W-1:0] coord_x,
    input logic signed [COORD_W-1:0] coord_y,
    input logic signed [COORD_W-1:0] coord_z,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [NOISE_W-1:0] noise_value
);

    // A stalled result holds its value until the transaction completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(noise_value))
        else $error("stalled result changed or dropped");

    // The input side only backs up when the whole pipeline is full and stalled.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while the pipeline had room");

    // The blend never leaves the corner value range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> noise_value != -(2 ** (NOISE_W - 1)))
        else $error("noise value out of range");

    // No result is shown while reset is applied.
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind hashed_value_noise_3d hvn_checker u_hvn_checker (.*);
